// ----- design/arbc_pkg.sv -----
// Shared types and constants for the audio ring buffer cursor manager.
package arbc_pkg;

  localparam int unsigned MAX_BUFFER_BYTES = 65536;
  localparam int unsigned POS_W            = 16;
  localparam int unsigned SIZE_W           = 17;
  localparam int unsigned CNT_W            = 32;
  localparam int unsigned REQ_W            = 3;

  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_BUFFER_BYTES);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);
  localparam logic [CNT_W-1:0]  UNDERRUN_SAT = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } state_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOCK   = 3'd0,
    REQ_COMMIT = 3'd1,
    REQ_READ   = 3'd2,
    REQ_PLAY   = 3'd3,
    REQ_STOP   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef struct packed {
    logic capture;
    logic execute;
    logic report;
  } ctrl_cmd_t;

endpackage

// ----- design/arbc_ctrl.sv -----
// Request sequencer: capture, execute, report, then result strobe.
module arbc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  output logic                  done_o,
  output arbc_pkg::ctrl_cmd_t   cmd_o
);

  arbc_pkg::state_e state_q, state_d;
  logic             done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arbc_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      arbc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = arbc_pkg::ST_EXEC;
        end
      end
      arbc_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = arbc_pkg::ST_REPORT;
      end
      arbc_pkg::ST_REPORT: begin
        cmd_o.report = 1'b1;
        done_d       = 1'b1;
        state_d      = arbc_pkg::ST_IDLE;
      end
      default: begin
        state_d = arbc_pkg::ST_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == arbc_pkg::ST_EXEC))
    else $error("accepted request did not enter execute");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##2 done_o)
    else $error("result strobe missing two cycles after execute");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && !$past(done_o)))
    else $error("result strobe repeated or while busy");

endmodule

// ----- design/arbc_datapath.sv -----
// Cursor state, request registers and per-request arithmetic.
module arbc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arbc_pkg::ctrl_cmd_t                 cmd_i,
  input  logic                                cfg_we_i,
  input  logic [arbc_pkg::SIZE_W-1:0]         cfg_wdata_i,
  output logic [arbc_pkg::SIZE_W-1:0]         cfg_size_o,
  input  logic [arbc_pkg::REQ_W-1:0]          req_type_i,
  input  logic [arbc_pkg::POS_W-1:0]          cursor_i,
  input  logic [arbc_pkg::SIZE_W-1:0]         byte_count_i,
  input  logic                                mode_flag_i,
  output logic [arbc_pkg::POS_W-1:0]          first_offset_o,
  output logic [arbc_pkg::SIZE_W-1:0]         first_len_o,
  output logic [arbc_pkg::POS_W-1:0]          second_len_o,
  output logic [arbc_pkg::SIZE_W-1:0]         granted_o,
  output logic [arbc_pkg::POS_W-1:0]          bytes_available_o,
  output logic [arbc_pkg::POS_W-1:0]          play_cursor_o,
  output logic [arbc_pkg::POS_W-1:0]          write_cursor_o,
  output logic                                is_playing_o,
  output logic                                is_looping_o,
  output logic [arbc_pkg::CNT_W-1:0]          underrun_total_o,
  output logic                                bad_cursor_o
);

  localparam int unsigned PW = arbc_pkg::POS_W;
  localparam int unsigned SW = arbc_pkg::SIZE_W;

  // configuration and cursor state
  logic [SW-1:0]                size_raw_q, size_q, size_eff;
  logic [PW-1:0]                write_q, write_d;
  logic [PW-1:0]                play_q, play_d;
  logic                         playing_q, playing_d;
  logic                         looping_q, looping_d;
  logic [arbc_pkg::CNT_W-1:0]   underrun_q, underrun_d;
  logic [PW-1:0]                avail_q, avail_d;

  // captured request
  logic [arbc_pkg::REQ_W-1:0]   req_q;
  logic [PW-1:0]                cursor_q;
  logic [SW-1:0]                count_q;
  logic                         mode_q;

  // result fields
  logic [PW-1:0] f_off_q, f_off_d;
  logic [SW-1:0] f_len_q, f_len_d;
  logic [PW-1:0] s_len_q, s_len_d;
  logic [SW-1:0] grant_q, grant_d;
  logic          bad_q, bad_d;

  // lock terms
  logic [SW-1:0] lk_room, lk_flen, lk_rest;
  logic [PW-1:0] lk_slen;
  logic          lk_bad;
  // read terms
  logic [SW-1:0] rd_avail, rd_n, rd_room, rd_flen, rd_slen;
  logic          rd_short;
  logic [SW:0]   rd_sum, rd_wrap;
  // commit terms
  logic [SW-1:0] cm_n;
  logic [SW:0]   cm_sum, cm_wrap;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      size_eff = arbc_pkg::SIZE_MIN;
    end else if (cfg_wdata_i > arbc_pkg::SIZE_MAX) begin
      size_eff = arbc_pkg::SIZE_MAX;
    end else begin
      size_eff = cfg_wdata_i;
    end
  end

  always_comb begin
    lk_bad  = {1'b0, cursor_q} >= size_q;
    lk_room = size_q - {1'b0, cursor_q};
    lk_flen = (count_q < lk_room) ? count_q : lk_room;
    lk_rest = count_q - lk_flen;
    lk_slen = (lk_rest < {1'b0, cursor_q}) ? lk_rest[PW-1:0] : cursor_q;

    rd_avail = {1'b0, avail_q};
    rd_short = rd_avail < count_q;
    rd_n     = rd_short ? rd_avail : count_q;
    rd_room  = size_q - {1'b0, play_q};
    rd_flen  = (rd_n < rd_room) ? rd_n : rd_room;
    rd_slen  = rd_n - rd_flen;
    rd_sum   = {2'b00, play_q} + {1'b0, rd_n};
    rd_wrap  = (rd_sum >= {1'b0, size_q}) ? rd_sum - {1'b0, size_q} : rd_sum;

    cm_n    = (count_q < size_q) ? count_q : size_q;
    cm_sum  = {2'b00, write_q} + {1'b0, cm_n};
    cm_wrap = (cm_sum >= {1'b0, size_q}) ? cm_sum - {1'b0, size_q} : cm_sum;
  end

  always_comb begin
    f_off_d    = '0;
    f_len_d    = '0;
    s_len_d    = '0;
    grant_d    = '0;
    bad_d      = 1'b0;
    write_d    = write_q;
    play_d     = play_q;
    playing_d  = playing_q;
    looping_d  = looping_q;
    underrun_d = underrun_q;
    case (arbc_pkg::req_e'(req_q))
      arbc_pkg::REQ_LOCK: begin
        if (mode_q) begin
          f_len_d = size_q;
        end else if (lk_bad) begin
          bad_d = 1'b1;
        end else begin
          f_off_d = cursor_q;
          f_len_d = lk_flen;
          s_len_d = lk_slen;
        end
      end
      arbc_pkg::REQ_COMMIT: begin
        write_d = cm_wrap[PW-1:0];
      end
      arbc_pkg::REQ_READ: begin
        f_off_d = play_q;
        f_len_d = rd_flen;
        s_len_d = rd_slen[PW-1:0];
        grant_d = rd_n;
        play_d  = rd_wrap[PW-1:0];
        if (rd_short && (underrun_q != arbc_pkg::UNDERRUN_SAT)) begin
          underrun_d = underrun_q + 1'b1;
        end
      end
      arbc_pkg::REQ_PLAY: begin
        playing_d = 1'b1;
        if (mode_q) begin
          looping_d = 1'b1;
        end
      end
      arbc_pkg::REQ_STOP: begin
        playing_d = 1'b0;
        looping_d = 1'b0;
      end
      arbc_pkg::REQ_CLEAR: begin
        underrun_d = '0;
      end
      default: begin
      end
    endcase
  end

  // distance from play to write on the updated cursors
  always_comb begin
    if (write_q >= play_q) begin
      avail_d = write_q - play_q;
    end else begin
      avail_d = PW'(({1'b0, write_q} + size_q) - {1'b0, play_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_raw_q <= arbc_pkg::SIZE_MAX;
      size_q     <= arbc_pkg::SIZE_MAX;
      write_q    <= '0;
      play_q     <= '0;
      playing_q  <= 1'b0;
      looping_q  <= 1'b0;
      underrun_q <= '0;
      avail_q    <= '0;
    end else if (cfg_we_i) begin
      size_raw_q <= cfg_wdata_i;
      size_q     <= size_eff;
      write_q    <= '0;
      play_q     <= '0;
      underrun_q <= '0;
      avail_q    <= '0;
    end else if (cmd_i.execute) begin
      write_q    <= write_d;
      play_q     <= play_d;
      playing_q  <= playing_d;
      looping_q  <= looping_d;
      underrun_q <= underrun_d;
    end else if (cmd_i.report) begin
      avail_q    <= avail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= req_type_i;
      cursor_q <= cursor_i;
      count_q  <= byte_count_i;
      mode_q   <= mode_flag_i;
    end
    if (cmd_i.execute) begin
      f_off_q <= f_off_d;
      f_len_q <= f_len_d;
      s_len_q <= s_len_d;
      grant_q <= grant_d;
      bad_q   <= bad_d;
    end
  end

  assign cfg_size_o        = size_raw_q;
  assign first_offset_o    = f_off_q;
  assign first_len_o       = f_len_q;
  assign second_len_o      = s_len_q;
  assign granted_o         = grant_q;
  assign bad_cursor_o      = bad_q;
  assign bytes_available_o = avail_q;
  assign play_cursor_o     = play_q;
  assign write_cursor_o    = write_q;
  assign is_playing_o      = playing_q;
  assign is_looping_o      = looping_q;
  assign underrun_total_o  = underrun_q;

endmodule

// ----- design/audio_ring_buffer_cursors.sv -----
// Top level of the audio ring buffer cursor manager: config port, sequencer, datapath.
// Sequence: an accepted request passes through the execute and report states, and its result
//   beat (done_o high) follows the report state; busy is high while execute and report run.
// A new request is not taken until the previous one has left the capture/execute/report sequence.
// Reset (rst_ni low, async): cursors, flags and underrun count clear, buffer size 65536.
// Results cannot be stalled: the beat is valid for the single done_o cycle only.
module audio_ring_buffer_cursors (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request command port
  input  logic                                start,
  output logic                                busy,
  input  logic [arbc_pkg::REQ_W-1:0]          req_type_i,
  input  logic [arbc_pkg::POS_W-1:0]          cursor_i,
  input  logic [arbc_pkg::SIZE_W-1:0]         byte_count_i,
  input  logic                                mode_flag_i,
  // result beat
  output logic                                done_o,
  output logic [arbc_pkg::POS_W-1:0]          first_offset_o,
  output logic [arbc_pkg::SIZE_W-1:0]         first_len_o,
  output logic [arbc_pkg::POS_W-1:0]          second_len_o,
  output logic [arbc_pkg::SIZE_W-1:0]         granted_o,
  output logic [arbc_pkg::POS_W-1:0]          bytes_available_o,
  output logic [arbc_pkg::POS_W-1:0]          play_cursor_o,
  output logic [arbc_pkg::POS_W-1:0]          write_cursor_o,
  output logic                                is_playing_o,
  output logic                                is_looping_o,
  output logic [arbc_pkg::CNT_W-1:0]          underrun_total_o,
  output logic                                bad_cursor_o,
  // APB config port; byte address 0 is buffer_size
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  arbc_pkg::ctrl_cmd_t          cmd;
  logic                         cfg_we;
  logic [arbc_pkg::SIZE_W-1:0]  cfg_size;

  // Zero-wait APB. Word select is paddr[2]; only word 0 exists, the
  // byte-lane bits are ignored. A size write also zeroes both cursors
  // and the underrun count (flags are kept).
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32 - arbc_pkg::SIZE_W){1'b0}}, cfg_size};

  arbc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Stored size is clamped to 1..MAX_BUFFER_BYTES; readback shows the raw value.
  arbc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (pwdata[arbc_pkg::SIZE_W-1:0]),
    .cfg_size_o        (cfg_size),
    .req_type_i        (req_type_i),
    .cursor_i          (cursor_i),
    .byte_count_i      (byte_count_i),
    .mode_flag_i       (mode_flag_i),
    .first_offset_o    (first_offset_o),
    .first_len_o       (first_len_o),
    .second_len_o      (second_len_o),
    .granted_o         (granted_o),
    .bytes_available_o (bytes_available_o),
    .play_cursor_o     (play_cursor_o),
    .write_cursor_o    (write_cursor_o),
    .is_playing_o      (is_playing_o),
    .is_looping_o      (is_looping_o),
    .underrun_total_o  (underrun_total_o),
    .bad_cursor_o      (bad_cursor_o)
  );

endmodule

// ----- verif/audio_ring_buffer_cursors_checker.sv -----
// Scoreboard for the ring buffer cursor manager: predicts each result beat and compares it.
`timescale 1ns / 1ps

module audio_ring_buffer_cursors_checker
  import arbc_pkg::*;
#(
  parameter logic [2:0] SIZE_ADDR = 3'd0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [POS_W-1:0]  cursor_i,
  input  logic [SIZE_W-1:0] byte_count_i,
  input  logic              mode_flag_i,
  input  logic              done_o,
  input  logic [POS_W-1:0]  first_offset_o,
  input  logic [SIZE_W-1:0] first_len_o,
  input  logic [POS_W-1:0]  second_len_o,
  input  logic [SIZE_W-1:0] granted_o,
  input  logic [POS_W-1:0]  bytes_available_o,
  input  logic [POS_W-1:0]  play_cursor_o,
  input  logic [POS_W-1:0]  write_cursor_o,
  input  logic              is_playing_o,
  input  logic              is_looping_o,
  input  logic [CNT_W-1:0]  underrun_total_o,
  input  logic              bad_cursor_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                in_flight,
  output int                fail_count
);

  typedef struct packed {
    logic [SIZE_W-1:0] size_reg;   // raw register value, clamped on use
    logic [POS_W-1:0]  wr_pos;
    logic [POS_W-1:0]  pl_pos;
    logic              playing;
    logic              looping;
    logic [CNT_W-1:0]  underruns;
  } cursor_state_t;

  typedef struct packed {
    logic [POS_W-1:0]  first_offset;
    logic [SIZE_W-1:0] first_len;
    logic [POS_W-1:0]  second_len;
    logic [SIZE_W-1:0] granted;
    logic [POS_W-1:0]  avail;
    logic [POS_W-1:0]  play_cur;
    logic [POS_W-1:0]  write_cur;
    logic              playing;
    logic              looping;
    logic [CNT_W-1:0]  underruns;
    logic              bad;
  } status_beat_t;

  cursor_state_t model;
  status_beat_t  beats_due[$];
  int            faults = 0;

  assign fail_count = faults;

  task automatic report_fault(string msg);
    faults++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_fault($sformatf("%s mismatch: got %h want %h", name, got, want));
  endtask

  // single conditional subtract, as the hardware does
  function automatic logic [POS_W-1:0] advance(logic [POS_W-1:0] pos, logic [SIZE_W-1:0] n,
                                               logic [SIZE_W-1:0] sz);
    logic [SIZE_W:0] sum;
    sum = pos + n;
    if (sum >= sz) sum = sum - sz;
    return sum[POS_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] fill_level(cursor_state_t st, logic [SIZE_W-1:0] sz);
    if (st.wr_pos >= st.pl_pos) return st.wr_pos - st.pl_pos;
    return st.wr_pos + sz - st.pl_pos;
  endfunction

  function automatic void predict_step(inout cursor_state_t st, input logic [REQ_W-1:0] rq,
                                       input logic [POS_W-1:0] cur,
                                       input logic [SIZE_W-1:0] cnt, input logic md,
                                       output status_beat_t beat);
    logic [SIZE_W-1:0] sz, room, n, av, rest;
    beat = '0;
    sz = (st.size_reg == '0) ? SIZE_MIN : (st.size_reg > SIZE_MAX) ? SIZE_MAX : st.size_reg;
    case (req_e'(rq))
      REQ_LOCK: begin
        if (md) begin
          beat.first_len = sz;
        end else if (cur >= sz) begin
          beat.bad = 1'b1;
        end else begin
          room = sz - cur;
          beat.first_offset = cur;
          beat.first_len = (cnt < room) ? cnt : room;
          if (beat.first_len < cnt) begin
            rest = cnt - beat.first_len;
            beat.second_len = (rest < cur) ? rest[POS_W-1:0] : cur;
          end
        end
      end
      REQ_COMMIT: begin
        n = (cnt < sz) ? cnt : sz;
        st.wr_pos = advance(st.wr_pos, n, sz);
      end
      REQ_READ: begin
        av = fill_level(st, sz);
        n = cnt;
        if (av < n) begin
          n = av;
          if (st.underruns != UNDERRUN_SAT) st.underruns = st.underruns + 1'b1;
        end
        room = sz - st.pl_pos;
        beat.first_offset = st.pl_pos;
        beat.first_len = (n < room) ? n : room;
        beat.second_len = POS_W'(n - beat.first_len);
        beat.granted = n;
        st.pl_pos = advance(st.pl_pos, n, sz);
      end
      REQ_PLAY: begin
        st.playing = 1'b1;
        if (md) st.looping = 1'b1;
      end
      REQ_STOP: begin
        st.playing = 1'b0;
        st.looping = 1'b0;
      end
      REQ_CLEAR: st.underruns = '0;
      default: ;
    endcase
    av = fill_level(st, sz);
    beat.avail = av[POS_W-1:0];
    beat.play_cur = st.pl_pos;
    beat.write_cur = st.wr_pos;
    beat.playing = st.playing;
    beat.looping = st.looping;
    beat.underruns = st.underruns;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cursor_state_t nxt;
    status_beat_t  want;
    if (!rst_ni) begin
      nxt = '0;
      nxt.size_reg = SIZE_MAX;
      model <= nxt;
      beats_due.delete();
      in_flight <= 0;
    end else begin
      nxt = model;
      if (done_o === 1'b1) begin
        if (beats_due.size() == 0) begin
          report_fault("result beat with nothing outstanding");
        end else begin
          want = beats_due.pop_front();
          check_field("first_offset", first_offset_o, want.first_offset);
          check_field("first_len", first_len_o, want.first_len);
          check_field("second_len", second_len_o, want.second_len);
          check_field("granted", granted_o, want.granted);
          check_field("bytes_available", bytes_available_o, want.avail);
          check_field("play_cursor", play_cursor_o, want.play_cur);
          check_field("write_cursor", write_cursor_o, want.write_cur);
          check_field("is_playing", is_playing_o, want.playing);
          check_field("is_looping", is_looping_o, want.looping);
          check_field("underrun_total", underrun_total_o, want.underruns);
          check_field("bad_cursor", bad_cursor_o, want.bad);
        end
      end else if ($isunknown(done_o)) begin
        report_fault("done_o unknown");
      end
      if (start && !busy) begin
        predict_step(nxt, req_type_i, cursor_i, byte_count_i, mode_flag_i, want);
        beats_due.push_back(want);
      end
      // size write also rewinds both cursors and the underrun count; flags survive
      if (psel && penable && pwrite && pready && paddr == SIZE_ADDR) begin
        nxt.size_reg = pwdata[SIZE_W-1:0];
        nxt.wr_pos = '0;
        nxt.pl_pos = '0;
        nxt.underruns = '0;
      end
      model <= nxt;
      in_flight <= beats_due.size();
    end
  end

endmodule

// ----- verif/audio_ring_buffer_cursors_tb.sv -----
// Testbench top for the ring buffer cursor manager: stimulus, size phases and verdict.
`timescale 1ns / 1ps

module audio_ring_buffer_cursors_tb;
  import arbc_pkg::*;

  // buffer_size register sits at byte address 0
  localparam logic [2:0]       SIZE_ADDR    = 3'd0;
  // request codes the block does not define; they must act as a no-op
  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;
  localparam int               N_PHASES     = 13;
  localparam int               PER_PHASE    = 150;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  req_type_i = '0;
  logic [POS_W-1:0]  cursor_i = '0;
  logic [SIZE_W-1:0] byte_count_i = '0;
  logic              mode_flag_i = 1'b0;
  logic              done_o;
  logic [POS_W-1:0]  first_offset_o;
  logic [SIZE_W-1:0] first_len_o;
  logic [POS_W-1:0]  second_len_o;
  logic [SIZE_W-1:0] granted_o;
  logic [POS_W-1:0]  bytes_available_o;
  logic [POS_W-1:0]  play_cursor_o;
  logic [POS_W-1:0]  write_cursor_o;
  logic              is_playing_o;
  logic              is_looping_o;
  logic [CNT_W-1:0]  underrun_total_o;
  logic              bad_cursor_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                in_flight;
  int                fail_count;

  // register values per phase: extremes, out-of-range values (0 acts as 1, above
  // 65536 clamps) and odd sizes where the modulo of a power of two would be wrong
  logic [31:0] size_plan [N_PHASES] = '{
    32'd1, 32'hFFFF_FFFF, 32'd7, 32'd65536, 32'd100, 32'd0, 32'd1000,
    32'd65537, 32'd3, 32'd4096, 32'd48000, 32'd2, 32'd65535
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  audio_ring_buffer_cursors i_dut (.*);

  audio_ring_buffer_cursors_checker #(.SIZE_ADDR(SIZE_ADDR)) i_checker (.*);

  // Present one request and hold it until the block takes it (start high, busy low).
  // Returns in the time step of the accepting edge, with start still high.
  task automatic issue(input logic [REQ_W-1:0] rq, input logic [POS_W-1:0] cur,
                       input logic [SIZE_W-1:0] cnt, input logic md);
    req_type_i <= rq;
    cursor_i <= cur;
    byte_count_i <= cnt;
    mode_flag_i <= md;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Stop sending and wait until every expected beat is back. The first edge lets
  // the checker count an item taken at the current edge.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  // APB write of buffer_size: setup cycle, then access until pready.
  // Block must be idle; the write also rewinds the cursors.
  task automatic write_size(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIZE_ADDR;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned      sz, pick, burst, last_commit;
    logic [31:0]      val;
    logic [REQ_W-1:0] rq;
    logic [POS_W-1:0] cur;
    logic [SIZE_W-1:0] cnt;
    logic             md;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed, at the reset size of 65536 ---
    issue(REQ_LOCK, '0, '0, 1'b0);                 // empty lock at offset zero
    issue(REQ_LOCK, 16'hFFFF, 17'h10000, 1'b0);    // last byte, rest wraps to zero
    issue(REQ_LOCK, 16'h8000, 17'h1FFFF, 1'b0);    // count beyond the buffer
    issue(REQ_LOCK, 16'hFFFF, '0, 1'b1);           // whole buffer, cursor ignored
    issue(REQ_READ, '0, 17'd10, 1'b0);             // read from empty: underrun
    issue(REQ_COMMIT, '0, 17'h1FFFF, 1'b0);        // commit saturates at size
    issue(REQ_COMMIT, '0, 17'd65535, 1'b0);
    issue(REQ_READ, '0, 17'h10000, 1'b0);          // clamped to 65535
    issue(REQ_COMMIT, '0, 17'd40000, 1'b0);        // write cursor wraps
    issue(REQ_READ, '0, 17'd30000, 1'b0);          // read region splits at the end
    issue(REQ_READ, '0, '0, 1'b0);
    issue(REQ_PLAY, '0, '0, 1'b0);
    issue(REQ_PLAY, '0, '0, 1'b1);                 // looping too
    issue(REQ_STOP, '0, '0, 1'b0);
    issue(REQ_CLEAR, '0, '0, 1'b0);
    issue(REQ_UNDEF_LO, 16'hFFFF, 17'h1FFFF, 1'b1);
    issue(REQ_UNDEF_HI, '0, '0, 1'b0);
    issue(REQ_PLAY, '0, '0, 1'b1);                 // flags must survive a size write
    drain_results();
    repeat (4) @(posedge clk_i);

    // zero size acts as one byte
    write_size(32'd0);
    issue(REQ_LOCK, '0, 17'd5, 1'b0);
    issue(REQ_LOCK, 16'd1, 17'd1, 1'b0);           // cursor at size: flagged
    issue(REQ_COMMIT, '0, 17'd3, 1'b0);
    issue(REQ_READ, '0, 17'd2, 1'b0);

    // --- random phases, one buffer size each ---
    burst = $urandom_range(1, 40);
    last_commit = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      repeat (4) @(posedge clk_i);
      val = size_plan[ph];
      if (val[31:SIZE_W] == '0) val[31:SIZE_W] = $urandom;   // junk above the field
      sz = val[SIZE_W-1:0];
      if (sz == 0) sz = 1;
      if (sz > MAX_BUFFER_BYTES) sz = MAX_BUFFER_BYTES;
      write_size(val);

      for (int i = 0; i < PER_PHASE; i++) begin
        // lock cursor: mostly inside the buffer, sometimes anywhere
        if ($urandom_range(0, 9) < 8) cur = $urandom_range(0, sz - 1);
        else cur = $urandom;
        case ($urandom_range(0, 5))
          0, 1:    cnt = $urandom_range(0, sz);
          2:       cnt = $urandom_range(0, (sz < 16) ? sz : 16);
          3:       cnt = sz;
          4:       cnt = $urandom;
          default: cnt = $urandom_range(0, 3);
        endcase
        md = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
          rq = REQ_LOCK;
          md = ($urandom_range(0, 6) == 0);
        end else if (pick < 46) begin
          rq = REQ_COMMIT;
          last_commit = cnt;
        end else if (pick < 72) begin
          // half the reads consume roughly what was just committed
          rq = REQ_READ;
          if ($urandom_range(0, 1)) cnt = last_commit + $urandom_range(0, 2);
        end else if (pick < 80) begin
          rq = REQ_PLAY;
        end else if (pick < 86) begin
          rq = REQ_STOP;
        end else if (pick < 92) begin
          rq = REQ_CLEAR;
        end else if (pick < 96) begin
          rq = REQ_UNDEF_LO;
        end else begin
          rq = REQ_UNDEF_HI;
        end
        issue(rq, cur, cnt, md);

        // bursts with random gaps; mid-phase, let the pipeline run dry once
        burst--;
        if (i == PER_PHASE / 2) begin
          drain_results();
        end
        if (burst == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
          burst = $urandom_range(1, 40);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && in_flight == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop; a correct run needs well under a tenth of this
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
